// ===== hw/rtl/line_segment_clipper_unit_macros.svh =====
`ifndef LINE_SEGMENT_CLIPPER_UNIT_MACROS_SVH
`define LINE_SEGMENT_CLIPPER_UNIT_MACROS_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define LSC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define LSC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/lsc_pkg.sv =====
`default_nettype none

package lsc_pkg;

   // Coordinates and the differences between them.
   localparam int COORD_W = 16;
   localparam int DIFF_W  = COORD_W + 1;
   // A difference of two coordinates never reaches -2**16, so its magnitude fits COORD_W bits.
   localparam int MAG_W   = COORD_W;
   localparam int PROD_W  = 2 * MAG_W;
   localparam int SUM_W   = PROD_W + 2;

   // Restoring divider: one quotient bit per cycle.
   localparam int DIV_CNT_W = $clog2(PROD_W);
   localparam logic [DIV_CNT_W-1:0] DIV_LAST = DIV_CNT_W'(PROD_W - 1);

   // Clip step bound.
   localparam int CLIP_CNT_W = 3;
   localparam logic [CLIP_CNT_W-1:0] MAX_CLIPS = CLIP_CNT_W'(4);

   // Outcode bits.
   localparam logic [3:0] CODE_LEFT  = 4'h1;
   localparam logic [3:0] CODE_RIGHT = 4'h2;
   localparam logic [3:0] CODE_BELOW = 4'h4;
   localparam logic [3:0] CODE_ABOVE = 4'h8;

   // Register map.
   localparam int CSR_INDEX_W = 8;
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_LEFT   = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_RIGHT  = CSR_INDEX_W'(1);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_BOTTOM = CSR_INDEX_W'(2);
   localparam logic [CSR_INDEX_W-1:0] CSR_WINDOW_TOP    = CSR_INDEX_W'(3);

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic [3:0] outcode_type;

   localparam coord_type WINDOW_LEFT_RESET   = COORD_W'(200);
   localparam coord_type WINDOW_RIGHT_RESET  = COORD_W'(400);
   localparam coord_type WINDOW_BOTTOM_RESET = COORD_W'(200);
   localparam coord_type WINDOW_TOP_RESET    = COORD_W'(400);

   // Controller to datapath.
   typedef struct packed {
      logic load;       // capture the request endpoints
      logic setup;      // choose the boundary and register the differences
      logic mult;       // register the numerator magnitude
      logic div_start;  // launch the divider
      logic write;      // move the chosen endpoint onto the boundary
   } lsc_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic start_inside;
      logic end_inside;
      logic trivial_reject;
      logic div_done;
   } lsc_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/lsc_divider.sv =====
`default_nettype none

module lsc_divider
   import lsc_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [PROD_W-1:0] dividend,
   input  wire logic [MAG_W-1:0]  divisor,
   output logic                   done,
   output logic [PROD_W-1:0]      quotient
);

   logic                 active_ff, active_in;
   logic                 done_ff, done_in;
   logic [DIV_CNT_W-1:0] cnt_ff, cnt_in;
   logic [PROD_W-1:0]    quo_ff, quo_in;
   logic [MAG_W-1:0]     rem_ff, rem_in;
   logic [MAG_W-1:0]     dsr_ff, dsr_in;
   logic [MAG_W:0]       shifted;
   logic [MAG_W:0]       trial;
   logic                 fits;

   // One restoring step: bring down the next dividend bit and try to subtract.
   assign shifted = {rem_ff, quo_ff[PROD_W-1]};
   assign trial   = shifted - {1'b0, dsr_ff};
   assign fits    = !trial[MAG_W];

   always_comb begin
      active_in = active_ff;
      done_in   = 1'b0;
      cnt_in    = cnt_ff;
      quo_in    = quo_ff;
      rem_in    = rem_ff;
      dsr_in    = dsr_ff;
      if (start) begin
         active_in = 1'b1;
         cnt_in    = '0;
         quo_in    = dividend;
         rem_in    = '0;
         dsr_in    = divisor;
      end else if (active_ff) begin
         quo_in = {quo_ff[PROD_W-2:0], fits};
         rem_in = fits ? trial[MAG_W-1:0] : shifted[MAG_W-1:0];
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == DIV_LAST) begin
            active_in = 1'b0;
            done_in   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         done_ff   <= 1'b0;
         cnt_ff    <= '0;
      end else begin
         active_ff <= active_in;
         done_ff   <= done_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lsc_datapath.sv =====
`default_nettype none

module lsc_datapath
   import lsc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire lsc_cmd_type            cmd,
   output lsc_status_type              status,
   input  wire coord_type              req_start_x,
   input  wire coord_type              req_start_y,
   input  wire coord_type              req_end_x,
   input  wire coord_type              req_end_y,
   input  wire logic                   csr_write,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]     csr_data,
   output coord_type                   pt_start_x,
   output coord_type                   pt_start_y,
   output coord_type                   pt_end_x,
   output coord_type                   pt_end_y
);

   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(2 ** (COORD_W - 1) - 1);
   localparam logic signed [SUM_W-1:0] SAT_LO = SUM_W'(-(2 ** (COORD_W - 1)));

   coord_type win_left_ff, win_right_ff, win_bottom_ff, win_top_ff;
   coord_type sx_ff, sy_ff, ex_ff, ey_ff;
   coord_type sx_in, sy_in, ex_in, ey_in;

   // Registered operands of one clip step.
   logic [MAG_W-1:0]  mag_a_ff, mag_b_ff, mag_den_ff;
   logic              neg_ff, den_zero_ff, move_start_ff, horiz_ff;
   coord_type         anchor_ff, bound_ff;
   logic [PROD_W-1:0] prod_ff;

   outcode_type code_start, code_end, code_sel;
   coord_type   a0_sel, a1_sel, b0_sel, b1_sel, bound_sel;
   logic        horiz_sel;
   logic signed [DIFF_W-1:0] diff_a, diff_b, diff_den;

   logic [PROD_W-1:0]        quotient;
   logic                     div_done;
   logic [SUM_W-1:0]         quo_ext;
   logic signed [SUM_W-1:0]  quo_signed, sum_full;
   coord_type                cross_coord;

   function automatic outcode_type outcode(input coord_type x, input coord_type y,
                                           input coord_type lft, input coord_type rgt,
                                           input coord_type bot, input coord_type top);
      outcode_type c;
      c = '0;
      if (x < lft) c = c | CODE_LEFT;
      if (x > rgt) c = c | CODE_RIGHT;
      if (y < bot) c = c | CODE_BELOW;
      if (y > top) c = c | CODE_ABOVE;
      return c;
   endfunction

   function automatic logic [MAG_W-1:0] magnitude(input logic signed [DIFF_W-1:0] v);
      logic signed [DIFF_W-1:0] n;
      n = v[DIFF_W-1] ? -v : v;
      return n[MAG_W-1:0];
   endfunction

   // Window registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         win_left_ff   <= WINDOW_LEFT_RESET;
         win_right_ff  <= WINDOW_RIGHT_RESET;
         win_bottom_ff <= WINDOW_BOTTOM_RESET;
         win_top_ff    <= WINDOW_TOP_RESET;
      end else if (csr_write) begin
         case (csr_index)
            CSR_WINDOW_LEFT:   win_left_ff   <= csr_data;
            CSR_WINDOW_RIGHT:  win_right_ff  <= csr_data;
            CSR_WINDOW_BOTTOM: win_bottom_ff <= csr_data;
            CSR_WINDOW_TOP:    win_top_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   assign code_start = outcode(sx_ff, sy_ff, win_left_ff, win_right_ff, win_bottom_ff,
                               win_top_ff);
   assign code_end   = outcode(ex_ff, ey_ff, win_left_ff, win_right_ff, win_bottom_ff,
                               win_top_ff);
   assign code_sel   = (code_start != '0) ? code_start : code_end;

   assign status.start_inside   = (code_start == '0);
   assign status.end_inside     = (code_end == '0);
   assign status.trivial_reject = |(code_start & code_end);
   assign status.div_done       = div_done;

   // Boundary choice: top, bottom, right, left. The start point is always the anchor.
   always_comb begin
      horiz_sel = 1'b1;
      a0_sel    = sx_ff;
      a1_sel    = ex_ff;
      b0_sel    = sy_ff;
      b1_sel    = ey_ff;
      bound_sel = win_top_ff;
      if (|(code_sel & CODE_ABOVE)) begin
         bound_sel = win_top_ff;
      end else if (|(code_sel & CODE_BELOW)) begin
         bound_sel = win_bottom_ff;
      end else begin
         horiz_sel = 1'b0;
         a0_sel    = sy_ff;
         a1_sel    = ey_ff;
         b0_sel    = sx_ff;
         b1_sel    = ex_ff;
         bound_sel = (|(code_sel & CODE_RIGHT)) ? win_right_ff : win_left_ff;
      end
   end

   assign diff_a   = DIFF_W'(a1_sel) - DIFF_W'(a0_sel);
   assign diff_b   = DIFF_W'(bound_sel) - DIFF_W'(b0_sel);
   assign diff_den = DIFF_W'(b1_sel) - DIFF_W'(b0_sel);

   always_ff @(posedge clock) begin
      if (cmd.setup) begin
         mag_a_ff      <= magnitude(diff_a);
         mag_b_ff      <= magnitude(diff_b);
         mag_den_ff    <= magnitude(diff_den);
         neg_ff        <= diff_a[DIFF_W-1] ^ diff_b[DIFF_W-1] ^ diff_den[DIFF_W-1];
         den_zero_ff   <= (diff_den == '0);
         move_start_ff <= (code_start != '0);
         horiz_ff      <= horiz_sel;
         anchor_ff     <= a0_sel;
         bound_ff      <= bound_sel;
      end
      if (cmd.mult) begin
         prod_ff <= PROD_W'(mag_a_ff) * PROD_W'(mag_b_ff);
      end
   end

   lsc_divider u_divider (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (prod_ff),
      .divisor  (mag_den_ff),
      .done     (div_done),
      .quotient (quotient)
   );

   // Sign the truncated quotient, add the anchor and saturate; a zero denominator gives the anchor.
   assign quo_ext    = SUM_W'(quotient);
   assign quo_signed = neg_ff ? -$signed(quo_ext) : $signed(quo_ext);
   assign sum_full   = SUM_W'(anchor_ff) + quo_signed;

   always_comb begin
      if (den_zero_ff) begin
         cross_coord = anchor_ff;
      end else if (sum_full > SAT_HI) begin
         cross_coord = SAT_HI[COORD_W-1:0];
      end else if (sum_full < SAT_LO) begin
         cross_coord = SAT_LO[COORD_W-1:0];
      end else begin
         cross_coord = sum_full[COORD_W-1:0];
      end
   end

   always_comb begin
      sx_in = sx_ff;
      sy_in = sy_ff;
      ex_in = ex_ff;
      ey_in = ey_ff;
      if (cmd.load) begin
         sx_in = req_start_x;
         sy_in = req_start_y;
         ex_in = req_end_x;
         ey_in = req_end_y;
      end else if (cmd.write) begin
         if (move_start_ff) begin
            sx_in = horiz_ff ? cross_coord : bound_ff;
            sy_in = horiz_ff ? bound_ff : cross_coord;
         end else begin
            ex_in = horiz_ff ? cross_coord : bound_ff;
            ey_in = horiz_ff ? bound_ff : cross_coord;
         end
      end
   end

   always_ff @(posedge clock) begin
      sx_ff <= sx_in;
      sy_ff <= sy_in;
      ex_ff <= ex_in;
      ey_ff <= ey_in;
   end

   assign pt_start_x = sx_ff;
   assign pt_start_y = sy_ff;
   assign pt_end_x   = ex_ff;
   assign pt_end_y   = ey_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/lsc_controller.sv =====
`default_nettype none

`include "line_segment_clipper_unit_macros.svh"

module lsc_controller
   import lsc_pkg::*;
(
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           start,
   input  wire lsc_status_type status,
   output lsc_cmd_type         cmd,
   output logic                busy,
   output logic                rsp_valid,
   output logic                rsp_accepted
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXAMINE,
      ST_SETUP,
      ST_MULT,
      ST_LAUNCH,
      ST_DIVIDE,
      ST_WRITE
   } state_type;

   state_type             state_ff, state_in;
   logic [CLIP_CNT_W-1:0] clips_ff, clips_in;
   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  accepted_ff, accepted_in;

   always_comb begin
      state_in     = state_ff;
      clips_in     = clips_ff;
      accepted_in  = accepted_ff;
      rsp_valid_in = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXAMINE;
               clips_in = '0;
            end
         end
         ST_EXAMINE: begin
            if (status.start_inside && status.end_inside) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               accepted_in  = 1'b1;
            end else if (status.trivial_reject || (clips_ff == MAX_CLIPS)) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               accepted_in  = 1'b0;
            end else begin
               state_in = ST_SETUP;
               clips_in = clips_ff + 1'b1;
            end
         end
         ST_SETUP:  state_in = ST_MULT;
         ST_MULT:   state_in = ST_LAUNCH;
         ST_LAUNCH: state_in = ST_DIVIDE;
         ST_DIVIDE: begin
            if (status.div_done) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE:  state_in = ST_EXAMINE;
         default:   state_in = ST_IDLE;
      endcase
      busy_in = (state_in != ST_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         clips_ff     <= '0;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         accepted_ff  <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clips_ff     <= clips_in;
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         accepted_ff  <= accepted_in;
      end
   end

   assign cmd.load      = (state_ff == ST_IDLE) && start;
   assign cmd.setup     = (state_ff == ST_SETUP);
   assign cmd.mult      = (state_ff == ST_MULT);
   assign cmd.div_start = (state_ff == ST_LAUNCH);
   assign cmd.write     = (state_ff == ST_WRITE);

   assign busy         = busy_ff;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_accepted = accepted_ff;

   `LSC_ASSERT_SAME(a_clip_bound, clock, reset, 1'b1, clips_ff <= MAX_CLIPS, "clip count overrun")
   `LSC_ASSERT_NEXT(a_single_strobe, clock, reset, rsp_valid_ff, !rsp_valid_ff, "strobe too long")
   `LSC_ASSERT_NEXT(a_start_busy, clock, reset, start && !busy_ff, busy_ff, "request not taken")
   `LSC_ASSERT_SAME(a_write_after_div, clock, reset, state_ff == ST_WRITE, $past(status.div_done), "write before quotient")

endmodule

`default_nettype wire

// ===== hw/rtl/line_segment_clipper_unit.sv =====
`default_nettype none

// Cohen-Sutherland line clipper. A request carries one segment as two signed 16-bit endpoints
// and is taken at the rising edge where start is high and busy is low. The segment is clipped
// against the window held in four registers, and one response comes back as a single-cycle
// strobe on rsp_valid with the accept flag and the final endpoints. The receiver cannot stall:
// the response must be captured in the cycle that rsp_valid is high. A request makes 0 to 4
// clip steps before its strobe. Each clip step runs the boundary selection, the multiply,
// the shared 32-step restoring divider (one quotient bit per cycle), the final add and the
// outcode check. busy drops in the strobe cycle, so the next request may be taken at the
// edge that ends that cycle.
module line_segment_clipper_unit
   import lsc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,

   // Request channel.
   input  wire logic                   start,
   output logic                        busy,
   input  wire coord_type              req_start_x,
   input  wire coord_type              req_start_y,
   input  wire coord_type              req_end_x,
   input  wire coord_type              req_end_y,

   // Response channel.
   output logic                        rsp_valid,
   output logic                        rsp_accepted,
   output coord_type                   rsp_clipped_start_x,
   output coord_type                   rsp_clipped_start_y,
   output coord_type                   rsp_clipped_end_x,
   output coord_type                   rsp_clipped_end_y,

   // Register write channel.
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire logic [CSR_INDEX_W-1:0] csr_index,
   input  wire logic [COORD_W-1:0]     csr_data
);

   lsc_cmd_type    cmd;
   lsc_status_type status;

   // Register writes are expected only between requests, so the channel is always open.
   // Writes to an index past the window registers are dropped.
   assign csr_ready = 1'b1;

   // The controller sequences the outcode check and the clip steps.
   lsc_controller u_controller (
      .clock        (clock),
      .reset        (reset),
      .start        (start),
      .status       (status),
      .cmd          (cmd),
      .busy         (busy),
      .rsp_valid    (rsp_valid),
      .rsp_accepted (rsp_accepted)
   );

   // The datapath holds the window, the current endpoints, the multiplier and the divider.
   // The endpoint registers stay put after the last step, so they serve as the response
   // payload in the strobe cycle.
   lsc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .status      (status),
      .req_start_x (req_start_x),
      .req_start_y (req_start_y),
      .req_end_x   (req_end_x),
      .req_end_y   (req_end_y),
      .csr_write   (csr_valid && csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .pt_start_x  (rsp_clipped_start_x),
      .pt_start_y  (rsp_clipped_start_y),
      .pt_end_x    (rsp_clipped_end_x),
      .pt_end_y    (rsp_clipped_end_y)
   );

endmodule

`default_nettype wire

// ===== dv/line_segment_clipper_checker.sv =====
module line_segment_clipper_checker
   import lsc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  logic                   busy,
   input  coord_type              req_start_x,
   input  coord_type              req_start_y,
   input  coord_type              req_end_x,
   input  coord_type              req_end_y,
   input  logic                   rsp_valid,
   input  logic                   rsp_accepted,
   input  coord_type              rsp_clipped_start_x,
   input  coord_type              rsp_clipped_start_y,
   input  coord_type              rsp_clipped_end_x,
   input  coord_type              rsp_clipped_end_y,
   input  logic                   csr_valid,
   input  logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [COORD_W-1:0]     csr_data,
   output int                     fail_count,
   output int                     pending_count,
   output int                     response_count,
   output int                     visible_count
);

   typedef struct packed {
      logic      accepted;
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } clip_result_type;

   coord_type       win_left;
   coord_type       win_right;
   coord_type       win_bottom;
   coord_type       win_top;
   clip_result_type clip_results_q[$];
   clip_result_type want;
   clip_result_type got;

   function automatic outcode_type region_code(input coord_type x, input coord_type y);
      outcode_type code;
      code = '0;
      if (x < win_left)   code |= CODE_LEFT;
      if (x > win_right)  code |= CODE_RIGHT;
      if (y < win_bottom) code |= CODE_BELOW;
      if (y > win_top)    code |= CODE_ABOVE;
      return code;
   endfunction

   // Point along the segment where coordinate b reaches the bound, anchored at (a0, b0).
   function automatic coord_type boundary_cross(input coord_type a0, input coord_type b0,
                                                input coord_type a1, input coord_type b1,
                                                input coord_type bound);
      longint span;
      longint value;
      span = longint'(b1) - longint'(b0);
      if (span == 0) return a0;
      value = longint'(a0) +
              (longint'(a1) - longint'(a0)) * (longint'(bound) - longint'(b0)) / span;
      if (value > 32767)  value = 32767;
      if (value < -32768) value = -32768;
      return coord_type'(value);
   endfunction

   function automatic clip_result_type clip_segment(input coord_type sx, input coord_type sy,
                                                    input coord_type ex, input coord_type ey);
      clip_result_type res;
      outcode_type     c1;
      outcode_type     c2;
      outcode_type     c;
      coord_type       nx;
      coord_type       ny;
      int              clips;
      logic            done;
      c1 = region_code(sx, sy);
      c2 = region_code(ex, ey);
      clips = 0;
      done = 1'b0;
      res.accepted = 1'b0;
      while (!done) begin
         if (c1 == '0 && c2 == '0) begin
            res.accepted = 1'b1;
            done = 1'b1;
         end else if ((c1 & c2) != '0 || clips >= int'(MAX_CLIPS)) begin
            done = 1'b1;
         end else begin
            clips++;
            c = (c1 != '0) ? c1 : c2;
            if ((c & CODE_ABOVE) != '0) begin
               nx = boundary_cross(sx, sy, ex, ey, win_top);
               ny = win_top;
            end else if ((c & CODE_BELOW) != '0) begin
               nx = boundary_cross(sx, sy, ex, ey, win_bottom);
               ny = win_bottom;
            end else if ((c & CODE_RIGHT) != '0) begin
               ny = boundary_cross(sy, sx, ey, ex, win_right);
               nx = win_right;
            end else begin
               ny = boundary_cross(sy, sx, ey, ex, win_left);
               nx = win_left;
            end
            if (c1 != '0) begin
               sx = nx;
               sy = ny;
               c1 = region_code(sx, sy);
            end else begin
               ex = nx;
               ey = ny;
               c2 = region_code(ex, ey);
            end
         end
      end
      res.sx = sx;
      res.sy = sy;
      res.ex = ex;
      res.ey = ey;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         win_left   <= WINDOW_LEFT_RESET;
         win_right  <= WINDOW_RIGHT_RESET;
         win_bottom <= WINDOW_BOTTOM_RESET;
         win_top    <= WINDOW_TOP_RESET;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_WINDOW_LEFT:   win_left   <= coord_type'(csr_data);
               CSR_WINDOW_RIGHT:  win_right  <= coord_type'(csr_data);
               CSR_WINDOW_BOTTOM: win_bottom <= coord_type'(csr_data);
               CSR_WINDOW_TOP:    win_top    <= coord_type'(csr_data);
               default: ;
            endcase
         end

         // The response is handled first: a new request may be taken at the same edge.
         if (rsp_valid) begin
            got = {rsp_accepted, rsp_clipped_start_x, rsp_clipped_start_y,
                   rsp_clipped_end_x, rsp_clipped_end_y};
            response_count <= response_count + 1;
            if (rsp_accepted) visible_count <= visible_count + 1;
            if (clip_results_q.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response with no request outstanding: %s%0b (%0d,%0d)-(%0d,%0d)",
                           $realtime, "acc=", got.accepted, got.sx, got.sy, got.ex, got.ey);
               fail_count <= fail_count + 1;
            end else begin
               want = clip_results_q.pop_front();
               if (got.accepted !== want.accepted || got.sx !== want.sx ||
                   got.sy !== want.sy || got.ex !== want.ex || got.ey !== want.ey) begin
                  if (fail_count < 10)
                     $display({"%0t: mismatch: expected acc=%0b (%0d,%0d)-(%0d,%0d),",
                               " got acc=%0b (%0d,%0d)-(%0d,%0d)"},
                              $realtime, want.accepted, want.sx, want.sy, want.ex, want.ey,
                              got.accepted, got.sx, got.sy, got.ex, got.ey);
                  fail_count <= fail_count + 1;
               end
            end
         end

         if (start && !busy)
            clip_results_q.push_back(clip_segment(req_start_x, req_start_y,
                                                  req_end_x, req_end_y));
      end
      pending_count <= clip_results_q.size();
   end

endmodule

// ===== dv/tb_top.sv =====
// Testbench for the line segment clipper. The top drives segment requests and window
// register writes; a checker beside the block predicts every response and compares it.
// The run starts with a directed set under the reset window and under an inverted window,
// then walks through a series of window settings with random segments in each.
module tb_top;
   import lsc_pkg::*;

   // Register indexes past the last window register; writes there must be ignored.
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_INDEX = CSR_INDEX_W'(4);
   localparam logic [CSR_INDEX_W-1:0] CSR_LAST_INDEX   = '1;

   // The tail leaves room for the longest request to finish, with margin.
   localparam int TAIL_CYCLES = 200;
   localparam int DRAIN_LIMIT = 5000;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   start = 1'b0;
   logic                   busy;
   coord_type              req_start_x = '0;
   coord_type              req_start_y = '0;
   coord_type              req_end_x = '0;
   coord_type              req_end_y = '0;
   logic                   rsp_valid;
   logic                   rsp_accepted;
   coord_type              rsp_clipped_start_x;
   coord_type              rsp_clipped_start_y;
   coord_type              rsp_clipped_end_x;
   coord_type              rsp_clipped_end_y;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [COORD_W-1:0]     csr_data = '0;

   int fail_count;
   int pending_count;
   int response_count;
   int visible_count;

   // Current window as programmed, used to aim random segments at it.
   int cur_left = 200;
   int cur_right = 400;
   int cur_bottom = 200;
   int cur_top = 400;
   int idle_pct = 0;
   int segment_count = 0;
   int window_count = 0;

   always #5 clock = ~clock;

   line_segment_clipper_unit u_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_start_x         (req_start_x),
      .req_start_y         (req_start_y),
      .req_end_x           (req_end_x),
      .req_end_y           (req_end_y),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_clipped_start_x (rsp_clipped_start_x),
      .rsp_clipped_start_y (rsp_clipped_start_y),
      .rsp_clipped_end_x   (rsp_clipped_end_x),
      .rsp_clipped_end_y   (rsp_clipped_end_y),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data)
   );

   line_segment_clipper_checker u_clip_checker (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_start_x         (req_start_x),
      .req_start_y         (req_start_y),
      .req_end_x           (req_end_x),
      .req_end_y           (req_end_y),
      .rsp_valid           (rsp_valid),
      .rsp_accepted        (rsp_accepted),
      .rsp_clipped_start_x (rsp_clipped_start_x),
      .rsp_clipped_start_y (rsp_clipped_start_y),
      .rsp_clipped_end_x   (rsp_clipped_end_x),
      .rsp_clipped_end_y   (rsp_clipped_end_y),
      .csr_valid           (csr_valid),
      .csr_ready           (csr_ready),
      .csr_index           (csr_index),
      .csr_data            (csr_data),
      .fail_count          (fail_count),
      .pending_count       (pending_count),
      .response_count      (response_count),
      .visible_count       (visible_count)
   );

   // Sends one request. With idling on, the sender first holds start low for a while:
   // mostly a short geometric gap, now and then a long one, so that the gaps end at
   // every point of the block's work. Handshake signals are sampled at the falling
   // edge, where they hold the value that the next rising edge will see.
   task automatic send_segment(input int sx, input int sy, input int ex, input int ey);
      int gap;
      bit taken;
      gap = 0;
      if (idle_pct != 0) begin
         if ($urandom_range(9) == 0) gap = $urandom_range(200);
         else while ($urandom_range(99) < idle_pct) gap++;
      end
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_start_x <= coord_type'(sx);
      req_start_y <= coord_type'(sy);
      req_end_x   <= coord_type'(ex);
      req_end_y   <= coord_type'(ey);
      start       <= 1'b1;
      do begin
         @(negedge clock);
         taken = !busy;
         @(posedge clock);
      end while (!taken);
      segment_count++;
   endtask

   // Drops start and waits until every outstanding response has come back, or until
   // the limit runs out; a response still missing then fails the run at the end.
   task automatic wait_drained();
      int waited;
      start <= 1'b0;
      waited = 0;
      do begin
         @(negedge clock);
         waited++;
      end while (pending_count != 0 && waited < DRAIN_LIMIT);
      @(posedge clock);
   endtask

   // Leaves csr_valid high on return so that back-to-back writes never pulse it low.
   task automatic write_register(input logic [CSR_INDEX_W-1:0] index, input int value);
      bit taken;
      csr_index <= index;
      csr_data  <= COORD_W'(value);
      csr_valid <= 1'b1;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
   endtask

   // Writes all four window registers, plus one write to an unused index that the
   // block must ignore. Only called while no request is in flight.
   task automatic program_window(input int left, input int right, input int bottom,
                                 input int top);
      write_register(CSR_WINDOW_LEFT, left);
      write_register(CSR_WINDOW_RIGHT, right);
      write_register(CSR_WINDOW_BOTTOM, bottom);
      write_register(CSR_WINDOW_TOP, top);
      write_register(CSR_INDEX_W'($urandom_range(CSR_LAST_INDEX, CSR_UNUSED_INDEX)),
                     int'($urandom_range(65535)) - 32768);
      csr_valid <= 1'b0;
      cur_left   = left;
      cur_right  = right;
      cur_bottom = bottom;
      cur_top    = top;
      window_count++;
   endtask

   // A random window no wider than max_size on each axis. An inverted window has its
   // bounds swapped, which is the only way a segment can run out of clip steps.
   task automatic program_random_window(input bit inverted, input int max_size);
      int x0, x1, y0, y1;
      x0 = int'($urandom_range(65535)) - 32768;
      y0 = int'($urandom_range(65535)) - 32768;
      x1 = x0 + int'($urandom_range(max_size));
      y1 = y0 + int'($urandom_range(max_size));
      if (x1 > 32767) x1 = 32767;
      if (y1 > 32767) y1 = 32767;
      if (inverted) program_window(x1, x0, y1, y0);
      else program_window(x0, x1, y0, y1);
   endtask

   // One coordinate aimed at the range between two bounds: mostly near the window, then
   // anywhere in the 16-bit range, on or just beside a bound, or at an extreme.
   function automatic int pick_coord(input int bound_a, input int bound_b);
      int lo, hi, span, mode, v;
      lo = (bound_a < bound_b) ? bound_a : bound_b;
      hi = (bound_a < bound_b) ? bound_b : bound_a;
      span = hi - lo + 64;
      mode = $urandom_range(99);
      if (mode < 50) begin
         v = lo - span + int'($urandom_range(hi - lo + 2 * span));
      end else if (mode < 70) begin
         v = int'($urandom_range(65535)) - 32768;
      end else if (mode < 85) begin
         case ($urandom_range(3))
            0: v = lo;
            1: v = hi;
            2: v = lo - 1;
            default: v = hi + 1;
         endcase
      end else begin
         v = ($urandom_range(1) == 0) ? -32768 : 32767;
      end
      if (v < -32768) v = -32768;
      if (v > 32767)  v = 32767;
      return v;
   endfunction

   task automatic run_random(input int count);
      repeat (count)
         send_segment(pick_coord(cur_left, cur_right), pick_coord(cur_bottom, cur_top),
                      pick_coord(cur_left, cur_right), pick_coord(cur_bottom, cur_top));
   endtask

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part under the reset window, which also checks the reset values.
      send_segment(250, 250, 350, 350);          // both ends inside
      send_segment(0, 300, 100, 300);            // both ends left of the window
      send_segment(250, 500, 350, 600);          // both ends above
      send_segment(0, 0, 600, 600);              // diagonal through two corners
      send_segment(300, 500, 300, 300);          // start above, end inside
      send_segment(300, 300, 300, 100);          // start inside, end below
      send_segment(500, 300, 100, 300);          // right to left across the window
      send_segment(300, 0, 300, 600);            // bottom to top across the window
      send_segment(100, 300, 300, 300);          // start left, end inside
      send_segment(300, 300, 500, 350);          // start inside, end right
      send_segment(-32768, -32768, 32767, 32767);
      send_segment(32767, -32768, -32768, 32767);
      send_segment(-32768, 32767, -32768, 32767);
      send_segment(200, 200, 400, 400);          // ends on the window corners
      send_segment(300, 300, 300, 300);          // point inside
      send_segment(100, 100, 100, 100);          // point outside
      send_segment(100, 350, 250, 450);          // clipped once, then rejected
      send_segment(150, 450, 450, 150);          // runs through the top left and bottom right corners
      send_segment(0, 250, 600, 450);            // clipped at both ends
      wait_drained();

      // Directed part under a window inverted on both axes.
      program_window(300, 100, 400, 200);
      send_segment(0, 0, 500, 500);
      send_segment(150, 300, 250, 300);
      send_segment(-32768, 32767, 32767, -32768);
      send_segment(50, 250, 350, 150);
      send_segment(350, 50, 50, 450);

      // Random part: one window setting per phase, each with its own idling.
      wait_drained();
      program_window(200, 400, 200, 400);
      idle_pct = 0;
      run_random(130);

      wait_drained();
      program_random_window(1'b0, 2000);
      idle_pct = 84;
      run_random(130);

      wait_drained();
      program_window(-32768, 32767, -32768, 32767);
      idle_pct = 22;
      run_random(90);

      wait_drained();
      program_window(0, 0, 0, 0);
      idle_pct = 0;
      run_random(90);

      wait_drained();
      program_random_window(1'b1, 2000);
      idle_pct = 84;
      run_random(110);

      wait_drained();
      program_random_window(1'b0, 65535);
      idle_pct = 22;
      run_random(130);

      wait_drained();
      program_window(32000, 32767, -32768, -32000);
      idle_pct = 0;
      run_random(110);

      wait_drained();
      program_random_window(1'b0, 300);
      run_random(110);

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Sent %0d segments across %0d window settings, idle from none to 84 percent.",
               segment_count, window_count);
      $display("Checked %0d responses: %0d visible, %0d rejected.",
               response_count, visible_count, response_count - visible_count);
      if (pending_count != 0)
         $display("%0d responses never arrived.", pending_count);
      if (fail_count == 0 && pending_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // The slowest correct run stays well under a fifth of this.
   initial begin
      #20000000;
      $display("Verification failed");
      $finish;
   end

endmodule
